// File: rtl/core/arb_pkg.sv
package arb_pkg;

  // general register count and result width are fixed by the word layout
  localparam int NUM_GENERAL = 32;
  localparam int RD_W        = 18;

  // defaults for the top-level parameters
  localparam int FLASH_WORDS_DEF = 262144;
  localparam int IRQ_LINES_DEF   = 64;

  localparam logic [15:0] SP_RESET   = 16'h21ff;
  localparam int          GIE_BIT    = 7;

  // register select codes above the general file
  localparam logic [5:0] SEL_GEN_LAST = 6'd31;
  localparam logic [5:0] SEL_STATUS   = 6'd32;
  localparam logic [5:0] SEL_SP       = 6'd33;
  localparam logic [5:0] SEL_RAMPZ    = 6'd34;
  localparam logic [5:0] SEL_EIND     = 6'd35;
  localparam logic [5:0] SEL_PC       = 6'd36;
  localparam logic [5:0] SEL_X        = 6'd37;
  localparam logic [5:0] SEL_Y        = 6'd38;
  localparam logic [5:0] SEL_Z        = 6'd39;

  // pointer pairs, low byte first
  localparam logic [4:0] REG_XL = 5'd26;
  localparam logic [4:0] REG_XH = 5'd27;
  localparam logic [4:0] REG_YL = 5'd28;
  localparam logic [4:0] REG_YH = 5'd29;
  localparam logic [4:0] REG_ZL = 5'd30;
  localparam logic [4:0] REG_ZH = 5'd31;

  typedef enum logic [2:0] {
    CMD_READ_REG  = 3'd0,
    CMD_WRITE_REG = 3'd1,
    CMD_READ_BIT  = 3'd2,
    CMD_WRITE_BIT = 3'd3,
    CMD_RAISE_IRQ = 3'd4,
    CMD_CANCEL_IRQ = 3'd5,
    CMD_TAKE_IRQ  = 3'd6,
    CMD_ADD_TICKS = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [5:0]  reg_sel;
    logic [31:0] write_value;
    logic [2:0]  status_bit;
    logic [5:0]  irq_line;
    logic [31:0] tick_count;
  } in_word_t;

  typedef struct packed {
    logic [RD_W-1:0] read_data;
    logic [5:0]      irq_number;
    logic            irq_valid;
    logic            irq_ready;
    logic [63:0]     cycle_count;
  } out_word_t;

  // one command word moving down the front pipe
  typedef struct packed {
    logic     vld;
    in_word_t word;
  } pipe_word_t;

endpackage

// File: rtl/core/arb_pcmod.sv
module arb_pcmod #(
  parameter int FLASH_WORDS = arb_pkg::FLASH_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  arb_pkg::pipe_word_t          pipe_in,
  output arb_pkg::pipe_word_t          pipe_out,
  output logic [$clog2(FLASH_WORDS)-1:0] pc_rem
);

  localparam int PC_W = $clog2(FLASH_WORDS);
  localparam int SHIFT = 31 + PC_W;
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(FLASH_WORDS);
  localparam logic [31:0] RECIP = RECIP_FULL[31:0];
  localparam int Q_W = 33 - PC_W;
  localparam logic [PC_W:0] FLASH_M = (PC_W+1)'(FLASH_WORDS);

  arb_pkg::pipe_word_t p1_r, p2_r, p3_r;
  logic [63:0]     prod;
  logic [Q_W-1:0]  q_r, q_nxt;
  logic [PC_W:0]   qf_r, qf_nxt;
  logic [PC_W:0]   diff;
  logic [PC_W-1:0] rem_r, rem_nxt;

  // quotient estimate, low by at most one
  assign prod  = 64'(pipe_in.word.write_value) * 64'(RECIP);
  assign q_nxt = Q_W'(prod >> SHIFT);

  assign qf_nxt = (PC_W+1)'(q_r * FLASH_M);

  always_comb begin
    diff = p2_r.word.write_value[PC_W:0] - qf_r;
    if (diff >= FLASH_M) begin
      diff = diff - FLASH_M;
    end
    rem_nxt = diff[PC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.vld <= 1'b0;
      p2_r.vld <= 1'b0;
      p3_r.vld <= 1'b0;
    end else begin
      p1_r.vld <= pipe_in.vld;
      p2_r.vld <= p1_r.vld;
      p3_r.vld <= p2_r.vld;
    end
    p1_r.word <= pipe_in.word;
    p2_r.word <= p1_r.word;
    p3_r.word <= p2_r.word;
    q_r       <= q_nxt;
    qf_r      <= qf_nxt;
    rem_r     <= rem_nxt;
  end

  assign pipe_out = p3_r;
  assign pc_rem   = rem_r;

endmodule

// File: rtl/core/arb_exec.sv
module arb_exec #(
  parameter int FLASH_WORDS = arb_pkg::FLASH_WORDS_DEF,
  parameter int IRQ_LINES   = arb_pkg::IRQ_LINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  arb_pkg::pipe_word_t            pipe_in,
  input  logic [$clog2(FLASH_WORDS)-1:0] pc_rem,
  output logic                           out_strobe,
  output arb_pkg::out_word_t             out_word
);

  localparam int PC_W      = $clog2(FLASH_WORDS);
  localparam int PC_KEEP_W = (PC_W < arb_pkg::RD_W) ? PC_W : arb_pkg::RD_W;

  arb_pkg::in_word_t w;
  logic vld;

  logic [7:0]           gen_r   [arb_pkg::NUM_GENERAL];
  logic [7:0]           gen_nxt [arb_pkg::NUM_GENERAL];
  logic [7:0]           status_r, status_nxt;
  logic [15:0]          sp_r, sp_nxt;
  logic [7:0]           rampz_r, rampz_nxt;
  logic [7:0]           eind_r, eind_nxt;
  logic [PC_KEEP_W-1:0] pc_r, pc_nxt;
  logic [IRQ_LINES-1:0] pend_r, pend_nxt;
  logic [63:0]          cyc_r, cyc_nxt;

  logic [IRQ_LINES-1:0] line_hit;
  logic [IRQ_LINES-1:0] low_bit;
  logic [5:0]           low_num;

  arb_pkg::out_word_t res, out_r;
  logic               strobe_r;

  assign w   = pipe_in.word;
  assign vld = pipe_in.vld;

  // line decode, out-of-range lines hit nothing
  always_comb begin
    for (int i = 0; i < IRQ_LINES; i++) begin
      line_hit[i] = (w.irq_line == 6'(i));
    end
  end

  // lowest pending line, isolated then encoded
  assign low_bit = pend_r & (~pend_r + IRQ_LINES'(1));

  always_comb begin
    low_num = '0;
    for (int i = 0; i < IRQ_LINES; i++) begin
      low_num = low_num | (6'(i) & {6{low_bit[i]}});
    end
  end

  always_comb begin
    gen_nxt    = gen_r;
    status_nxt = status_r;
    sp_nxt     = sp_r;
    rampz_nxt  = rampz_r;
    eind_nxt   = eind_r;
    pc_nxt     = pc_r;
    pend_nxt   = pend_r;
    cyc_nxt    = cyc_r;
    res        = '0;

    case (w.cmd)
      arb_pkg::CMD_READ_REG: begin
        case (w.reg_sel) inside
          [6'd0:arb_pkg::SEL_GEN_LAST]: res.read_data = arb_pkg::RD_W'(gen_r[w.reg_sel[4:0]]);
          arb_pkg::SEL_STATUS: res.read_data = arb_pkg::RD_W'(status_r);
          arb_pkg::SEL_SP:     res.read_data = arb_pkg::RD_W'(sp_r);
          arb_pkg::SEL_RAMPZ:  res.read_data = arb_pkg::RD_W'(rampz_r);
          arb_pkg::SEL_EIND:   res.read_data = arb_pkg::RD_W'(eind_r);
          arb_pkg::SEL_PC:     res.read_data = arb_pkg::RD_W'(pc_r);
          arb_pkg::SEL_X: res.read_data = {2'b00, gen_r[arb_pkg::REG_XH], gen_r[arb_pkg::REG_XL]};
          arb_pkg::SEL_Y: res.read_data = {2'b00, gen_r[arb_pkg::REG_YH], gen_r[arb_pkg::REG_YL]};
          arb_pkg::SEL_Z: res.read_data = {2'b00, gen_r[arb_pkg::REG_ZH], gen_r[arb_pkg::REG_ZL]};
          default:             res.read_data = '0;
        endcase
      end
      arb_pkg::CMD_WRITE_REG: begin
        case (w.reg_sel) inside
          [6'd0:arb_pkg::SEL_GEN_LAST]: gen_nxt[w.reg_sel[4:0]] = w.write_value[7:0];
          arb_pkg::SEL_STATUS: status_nxt = w.write_value[7:0];
          arb_pkg::SEL_SP:     sp_nxt     = w.write_value[15:0];
          arb_pkg::SEL_RAMPZ:  rampz_nxt  = w.write_value[7:0];
          arb_pkg::SEL_EIND:   eind_nxt   = w.write_value[7:0];
          arb_pkg::SEL_PC:     pc_nxt     = pc_rem[PC_KEEP_W-1:0];
          arb_pkg::SEL_X: begin
            gen_nxt[arb_pkg::REG_XL] = w.write_value[7:0];
            gen_nxt[arb_pkg::REG_XH] = w.write_value[15:8];
          end
          arb_pkg::SEL_Y: begin
            gen_nxt[arb_pkg::REG_YL] = w.write_value[7:0];
            gen_nxt[arb_pkg::REG_YH] = w.write_value[15:8];
          end
          arb_pkg::SEL_Z: begin
            gen_nxt[arb_pkg::REG_ZL] = w.write_value[7:0];
            gen_nxt[arb_pkg::REG_ZH] = w.write_value[15:8];
          end
          default: ;
        endcase
      end
      arb_pkg::CMD_READ_BIT: begin
        res.read_data = arb_pkg::RD_W'(status_r[w.status_bit]);
      end
      arb_pkg::CMD_WRITE_BIT: begin
        status_nxt[w.status_bit] = |w.write_value;
      end
      arb_pkg::CMD_RAISE_IRQ: begin
        pend_nxt = pend_r | line_hit;
      end
      arb_pkg::CMD_CANCEL_IRQ: begin
        pend_nxt = pend_r & ~line_hit;
      end
      arb_pkg::CMD_TAKE_IRQ: begin
        if (|pend_r) begin
          pend_nxt       = pend_r & ~low_bit;
          res.irq_valid  = 1'b1;
          res.irq_number = low_num;
        end
      end
      arb_pkg::CMD_ADD_TICKS: begin
        cyc_nxt = cyc_r + 64'(w.tick_count);
      end
      default: ;
    endcase

    res.irq_ready   = status_nxt[arb_pkg::GIE_BIT] & (|pend_nxt);
    res.cycle_count = cyc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < arb_pkg::NUM_GENERAL; i++) begin
        gen_r[i] <= '0;
      end
      status_r <= '0;
      sp_r     <= arb_pkg::SP_RESET;
      rampz_r  <= '0;
      eind_r   <= '0;
      pc_r     <= '0;
      pend_r   <= '0;
      cyc_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld;
      if (vld) begin
        gen_r    <= gen_nxt;
        status_r <= status_nxt;
        sp_r     <= sp_nxt;
        rampz_r  <= rampz_nxt;
        eind_r   <= eind_nxt;
        pc_r     <= pc_nxt;
        pend_r   <= pend_nxt;
        cyc_r    <= cyc_nxt;
      end
    end
    if (vld) begin
      out_r <= res;
    end
  end

  assign out_strobe = strobe_r;
  assign out_word   = out_r;

  a_valid_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    vld && (w.cmd != arb_pkg::CMD_TAKE_IRQ) |=> !out_r.irq_valid)
    else $error("irq_valid set by a command other than take");

  a_cycles_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(vld && (w.cmd == arb_pkg::CMD_ADD_TICKS)) |=> $stable(cyc_r))
    else $error("cycle counter moved without an add-ticks command");

  a_take_clears_one: assert property (@(posedge clk) disable iff (!rst_n)
    vld && (w.cmd == arb_pkg::CMD_TAKE_IRQ) && (|pend_r)
    |=> $countones(pend_r) == $countones($past(pend_r)) - 1)
    else $error("take did not clear exactly one pending line");

  a_ready_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> out_r.irq_ready == (status_r[arb_pkg::GIE_BIT] && (|pend_r)))
    else $error("irq_ready disagrees with stored state");

  a_cycle_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> out_r.cycle_count == cyc_r)
    else $error("reported cycle count disagrees with counter");

endmodule

// File: rtl/core/avr_register_bank.sv
// avr-style register bank: 32 byte registers, status, stack pointer, rampz, eind,
// program counter, pending interrupt set and 64-bit cycle counter. a command word
// is taken whenever start is high; busy never rises, so one word can enter every
// cycle and the sustained rate is one word per clock. each word yields exactly one
// result word on out_word, marked by out_strobe for a single cycle. the strobe rises
// once the word has passed the input register, three stages that reduce the written
// value modulo the flash size for program counter writes, execute and the result
// register. the receiver cannot stall: results must be captured the cycle they
// appear. words are carried out strictly in order, and each one sees every state
// change made by the words before it.
module avr_register_bank #(
  parameter int FLASH_WORDS = arb_pkg::FLASH_WORDS_DEF,
  parameter int IRQ_LINES   = arb_pkg::IRQ_LINES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  arb_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output arb_pkg::out_word_t out_word
);

  arb_pkg::pipe_word_t in_r;
  arb_pkg::pipe_word_t prep_word;
  logic [$clog2(FLASH_WORDS)-1:0] pc_rem;

  // fully pipelined, nothing ever blocks the input side
  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.vld <= 1'b0;
    end else begin
      in_r.vld <= start & ~busy;
    end
    in_r.word <= in_word;
  end

  // pc reduction runs alongside the word so execute sees it ready
  arb_pcmod #(
    .FLASH_WORDS (FLASH_WORDS)
  ) u_pcmod (
    .clk      (clk),
    .rst_n    (rst_n),
    .pipe_in  (in_r),
    .pipe_out (prep_word),
    .pc_rem   (pc_rem)
  );

  // state lives here, one word executes per cycle
  arb_exec #(
    .FLASH_WORDS (FLASH_WORDS),
    .IRQ_LINES   (IRQ_LINES)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_in    (prep_word),
    .pc_rem     (pc_rem),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
